@@ hw/rtl/tphq_pkg.sv @@
// types, widths and axis codes for the triangle plane height query unit
// used by every module of the block; depends on nothing
package tphq_pkg;

  localparam int CW    = 24;           // coordinate width, signed Q12.12
  localparam int DW    = CW + 1;       // edge and offset differences
  localparam int PW    = 2 * DW;       // one edge product
  localparam int NW    = PW + 1;       // normal component
  localparam int NL_W  = NW / 2;       // low part of a split normal
  localparam int NH_W  = NW - NL_W;    // high part of a split normal
  localparam int HH_W  = NH_W + DW;    // high partial product
  localparam int LL_W  = NL_W + 1 + DW;// low partial product
  localparam int FW    = NW + DW;      // full normal times offset
  localparam int NUMW  = FW + 2;       // sum of three products
  localparam int QD    = 2;            // queue depth

  localparam logic [1:0] AXIS_Z = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_X = 2'd2;
  localparam logic [1:0] AXIS_BAD = 2'd3;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [DW-1:0]   diff_t;
  typedef logic signed [PW-1:0]   eprod_t;
  typedef logic signed [NW-1:0]   norm_t;
  typedef logic signed [HH_W-1:0] hh_t;
  typedef logic signed [LL_W-1:0] ll_t;
  typedef logic signed [FW-1:0]   fprod_t;
  typedef logic signed [NUMW-1:0] num_t;
  typedef logic [NUMW-1:0]        mag_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t first_x;
    coord_t first_y;
    coord_t first_z;
    coord_t second_x;
    coord_t second_y;
    coord_t second_z;
    coord_t third_x;
    coord_t third_y;
    coord_t third_z;
  } query_t;

  typedef struct packed {
    coord_t height;
    logic   degenerate;
    logic   saturated;
  } result_t;

  // one classified query, reordered to solved axis s and the other two i, j
  typedef struct packed {
    diff_t  ab_s;
    diff_t  ab_i;
    diff_t  ab_j;
    diff_t  ac_s;
    diff_t  ac_i;
    diff_t  ac_j;
    diff_t  d_i;
    diff_t  d_j;
    coord_t a_s;
  } entry_t;

  typedef struct packed {
    logic full;
    logic vld;
  } qstat_t;

endpackage

@@ hw/rtl/tphq_front.sv @@
// front end: up axis register, accept, axis reorder and differences
// depends on tphq_pkg
module tphq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tphq_pkg::query_t  cmd_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  tphq_pkg::qstat_t  qstat_i,
  output logic              push_o,
  output tphq_pkg::entry_t  entry_o
);

  logic [1:0] axis_q, axis_d;
  tphq_pkg::coord_t p_s, p_i, p_j, a_s, a_i, a_j, b_s, b_i, b_j, c_s, c_i, c_j;

  always_comb begin
    axis_d = axis_q;
    if (cfg_we_i && (cfg_wdata_i != tphq_pkg::AXIS_BAD)) begin
      axis_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= tphq_pkg::AXIS_Y;
    end else begin
      axis_q <= axis_d;
    end
  end

  assign busy   = qstat_i.full;
  assign push_o = start && !qstat_i.full;

  // s is the solved axis, i and j follow it cyclically
  always_comb begin
    case (axis_q)
      tphq_pkg::AXIS_Z: begin
        p_s = cmd_i.point_z;  p_i = cmd_i.point_x;  p_j = cmd_i.point_y;
        a_s = cmd_i.first_z;  a_i = cmd_i.first_x;  a_j = cmd_i.first_y;
        b_s = cmd_i.second_z; b_i = cmd_i.second_x; b_j = cmd_i.second_y;
        c_s = cmd_i.third_z;  c_i = cmd_i.third_x;  c_j = cmd_i.third_y;
      end
      tphq_pkg::AXIS_X: begin
        p_s = cmd_i.point_x;  p_i = cmd_i.point_y;  p_j = cmd_i.point_z;
        a_s = cmd_i.first_x;  a_i = cmd_i.first_y;  a_j = cmd_i.first_z;
        b_s = cmd_i.second_x; b_i = cmd_i.second_y; b_j = cmd_i.second_z;
        c_s = cmd_i.third_x;  c_i = cmd_i.third_y;  c_j = cmd_i.third_z;
      end
      default: begin
        p_s = cmd_i.point_y;  p_i = cmd_i.point_z;  p_j = cmd_i.point_x;
        a_s = cmd_i.first_y;  a_i = cmd_i.first_z;  a_j = cmd_i.first_x;
        b_s = cmd_i.second_y; b_i = cmd_i.second_z; b_j = cmd_i.second_x;
        c_s = cmd_i.third_y;  c_i = cmd_i.third_z;  c_j = cmd_i.third_x;
      end
    endcase
  end

  // the point's own s coordinate does not enter the plane equation
  always_comb begin
    entry_o.ab_s = tphq_pkg::diff_t'(b_s) - tphq_pkg::diff_t'(a_s);
    entry_o.ab_i = tphq_pkg::diff_t'(b_i) - tphq_pkg::diff_t'(a_i);
    entry_o.ab_j = tphq_pkg::diff_t'(b_j) - tphq_pkg::diff_t'(a_j);
    entry_o.ac_s = tphq_pkg::diff_t'(c_s) - tphq_pkg::diff_t'(a_s);
    entry_o.ac_i = tphq_pkg::diff_t'(c_i) - tphq_pkg::diff_t'(a_i);
    entry_o.ac_j = tphq_pkg::diff_t'(c_j) - tphq_pkg::diff_t'(a_j);
    entry_o.d_i  = tphq_pkg::diff_t'(p_i) - tphq_pkg::diff_t'(a_i);
    entry_o.d_j  = tphq_pkg::diff_t'(p_j) - tphq_pkg::diff_t'(a_j);
    entry_o.a_s  = a_s ^ (p_s & '0);
  end

endmodule

@@ hw/rtl/tphq_queue.sv @@
// short queue between front and back end, drained every cycle it holds data
// depends on tphq_pkg
module tphq_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tphq_pkg::entry_t  data_i,
  output tphq_pkg::qstat_t  qstat_o,
  output tphq_pkg::entry_t  data_o
);

  tphq_pkg::entry_t mem_q [tphq_pkg::QD];
  logic wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic pop;

  assign pop          = (cnt_q != 2'd0);
  assign qstat_o.vld  = pop;
  assign qstat_o.full = (cnt_q == 2'(tphq_pkg::QD));
  assign data_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/tphq_back.sv @@
// back end: cross product, plane equation, restoring divider, saturation
// depends on tphq_pkg
module tphq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  tphq_pkg::entry_t  entry_i,
  output logic              done_o,
  output tphq_pkg::result_t res_o
);

  localparam int CW = tphq_pkg::CW;
  localparam int NL_W = tphq_pkg::NL_W;
  localparam int NW = tphq_pkg::NW;

  // stage valids: 1 products, 2 normal, 3 partials, 4 full products,
  // 5 numerator, 6 magnitudes
  logic [6:1] v_q;
  logic [CW:0] dv_q;
  logic out_v_q;

  // stage 1
  tphq_pkg::eprod_t p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q;
  tphq_pkg::diff_t  di1_q, dj1_q, as1_q;
  // stage 2
  tphq_pkg::norm_t  ns2_q, ni2_q, nj2_q;
  tphq_pkg::diff_t  di2_q, dj2_q, as2_q;
  // stage 3
  tphq_pkg::hh_t    hi3_q, hj3_q, hs3_q;
  tphq_pkg::ll_t    li3_q, lj3_q, ls3_q;
  tphq_pkg::norm_t  ns3_q;
  // stage 4
  tphq_pkg::fprod_t fi4_q, fj4_q, fs4_q;
  tphq_pkg::norm_t  ns4_q;
  // stage 5
  tphq_pkg::num_t   num5_q;
  tphq_pkg::norm_t  ns5_q;
  // stage 6
  tphq_pkg::mag_t   an6_q;
  logic [NW-1:0]    ad6_q;
  logic             neg6_q, deg6_q;
  // divider stages
  tphq_pkg::mag_t   rem_q [CW+1];
  logic [NW-1:0]    den_q [CW+1];
  logic [CW-1:0]    quo_q [CW+1];
  logic             neg_q [CW+1];
  logic             deg_q [CW+1];
  logic             ovf_q [CW+1];
  // output register
  tphq_pkg::result_t res_q;

  tphq_pkg::mag_t   trial [CW];
  logic             take  [CW];
  logic [CW-1:0]    lim, quo_sat;
  logic             sat;

  always_comb begin
    for (int k = 0; k < CW; k++) begin
      trial[k] = rem_q[k] - (tphq_pkg::mag_t'(den_q[k]) << (CW - 1 - k));
      take[k]  = rem_q[k] >= (tphq_pkg::mag_t'(den_q[k]) << (CW - 1 - k));
    end
  end

  // clamp magnitude; a negative result may reach one step further
  always_comb begin
    lim     = neg_q[CW] ? CW'(1) << (CW - 1) : (CW'(1) << (CW - 1)) - CW'(1);
    sat     = ovf_q[CW] || (quo_q[CW] > lim);
    quo_sat = sat ? lim : quo_q[CW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q     <= {v_q[5:1], vld_i};
      dv_q    <= {dv_q[CW-1:0], v_q[6]};
      out_v_q <= dv_q[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    // edge products, cyclic in s, i, j
    p1a_q <= entry_i.ab_i * entry_i.ac_j;
    p1b_q <= entry_i.ab_j * entry_i.ac_i;
    p2a_q <= entry_i.ab_j * entry_i.ac_s;
    p2b_q <= entry_i.ab_s * entry_i.ac_j;
    p3a_q <= entry_i.ab_s * entry_i.ac_i;
    p3b_q <= entry_i.ab_i * entry_i.ac_s;
    di1_q <= entry_i.d_i;
    dj1_q <= entry_i.d_j;
    as1_q <= tphq_pkg::diff_t'(entry_i.a_s);

    ns2_q <= tphq_pkg::norm_t'(p1a_q) - tphq_pkg::norm_t'(p1b_q);
    ni2_q <= tphq_pkg::norm_t'(p2a_q) - tphq_pkg::norm_t'(p2b_q);
    nj2_q <= tphq_pkg::norm_t'(p3a_q) - tphq_pkg::norm_t'(p3b_q);
    di2_q <= di1_q;
    dj2_q <= dj1_q;
    as2_q <= as1_q;

    // normal split into a signed high half and an unsigned low half
    hi3_q <= $signed(ni2_q[NW-1:NL_W]) * di2_q;
    hj3_q <= $signed(nj2_q[NW-1:NL_W]) * dj2_q;
    hs3_q <= $signed(ns2_q[NW-1:NL_W]) * as2_q;
    li3_q <= $signed({1'b0, ni2_q[NL_W-1:0]}) * di2_q;
    lj3_q <= $signed({1'b0, nj2_q[NL_W-1:0]}) * dj2_q;
    ls3_q <= $signed({1'b0, ns2_q[NL_W-1:0]}) * as2_q;
    ns3_q <= ns2_q;

    fi4_q <= (tphq_pkg::fprod_t'(hi3_q) <<< NL_W) + tphq_pkg::fprod_t'(li3_q);
    fj4_q <= (tphq_pkg::fprod_t'(hj3_q) <<< NL_W) + tphq_pkg::fprod_t'(lj3_q);
    fs4_q <= (tphq_pkg::fprod_t'(hs3_q) <<< NL_W) + tphq_pkg::fprod_t'(ls3_q);
    ns4_q <= ns3_q;

    num5_q <= tphq_pkg::num_t'(fs4_q) - tphq_pkg::num_t'(fi4_q)
            - tphq_pkg::num_t'(fj4_q);
    ns5_q  <= ns4_q;

    neg6_q <= num5_q[tphq_pkg::NUMW-1] ^ ns5_q[NW-1];
    deg6_q <= (ns5_q == '0);
    an6_q  <= num5_q[tphq_pkg::NUMW-1] ? tphq_pkg::mag_t'(-num5_q)
                                       : tphq_pkg::mag_t'(num5_q);
    ad6_q  <= ns5_q[NW-1] ? NW'(-ns5_q) : NW'(ns5_q);

    // a quotient of 2^CW or more always clamps
    rem_q[0] <= an6_q;
    den_q[0] <= ad6_q;
    quo_q[0] <= '0;
    neg_q[0] <= neg6_q;
    deg_q[0] <= deg6_q;
    ovf_q[0] <= an6_q >= (tphq_pkg::mag_t'(ad6_q) << CW);

    for (int k = 0; k < CW; k++) begin
      rem_q[k+1] <= take[k] ? trial[k] : rem_q[k];
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= {quo_q[k][CW-2:0], take[k]};
      neg_q[k+1] <= neg_q[k];
      deg_q[k+1] <= deg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end

    if (deg_q[CW]) begin
      res_q.height     <= '0;
      res_q.degenerate <= 1'b1;
      res_q.saturated  <= 1'b0;
    end else begin
      res_q.height     <= neg_q[CW] ? tphq_pkg::coord_t'(-quo_sat)
                                    : tphq_pkg::coord_t'(quo_sat);
      res_q.degenerate <= 1'b0;
      res_q.saturated  <= sat;
    end
  end

  assign done_o = out_v_q;
  assign res_o  = res_q;

endmodule

@@ hw/rtl/triangle_plane_height_query_unit.sv @@
// triangle plane height query unit, top level
// depends on tphq_pkg, tphq_front, tphq_queue, tphq_back
//
// A query (point and triangle vertices A, B, C, signed Q12.12) is taken at a
// rising edge with start high and busy low. The front end reorders the axes
// for the solved axis and forms the edge and offset differences into a
// two-entry queue; the back end pipeline builds the normal by cross product,
// evaluates the plane equation exactly and divides with a restoring divider
// of one quotient bit per stage.
// The result appears on res_o with done_o high for exactly one cycle, after
// passing the queue, the product and sum stages and the 24 divider stages
// behind them. One query per cycle is sustained, the back end drains the
// queue every cycle, so busy stays low in normal use. The receiver cannot
// stall: every transfer on res_o must be taken in its cycle.
// cfg_we_i writes up_axis from cfg_wdata_i (0 solves z, 1 y, 2 x; 3 is
// ignored); write only while no query is in flight. Reset clears the
// pipeline and sets up_axis to 1; results in flight are dropped.
module triangle_plane_height_query_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tphq_pkg::query_t  cmd_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  output logic              done_o,
  output tphq_pkg::result_t res_o
);

  tphq_pkg::qstat_t qstat;
  tphq_pkg::entry_t push_data, pop_data;
  logic push;

  tphq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_data)
  );

  tphq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .qstat_o (qstat),
    .data_o  (pop_data)
  );

  tphq_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (qstat.vld),
    .entry_i (pop_data),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

@@ dv/tb.sv @@
// testbench for triangle_plane_height_query_unit: random and corner queries on every axis
// depends on tphq_pkg and the unit's rtl; exact predictor compares every result transfer
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  tphq_pkg::query_t  cmd_i;
  logic              cfg_we_i;
  logic [1:0]        cfg_wdata_i;
  logic              done_o;
  tphq_pkg::result_t res_o;

  triangle_plane_height_query_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o), .res_o(res_o)
  );

  tphq_pkg::query_t  query_backlog[$];
  tphq_pkg::result_t height_expect[$];
  logic [1:0]        solve_axis;
  int                send_idle_pct;
  int                fail_count;
  int                accepted_count;
  int                degenerate_seen;
  int                saturated_seen;
  int                cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // exact plane solve, quotient truncated toward zero then clamped
  function automatic tphq_pkg::result_t plane_height(tphq_pkg::query_t q, logic [1:0] axis);
    logic signed [127:0] pt[3];
    logic signed [127:0] va[3];
    logic signed [127:0] ab[3];
    logic signed [127:0] ac[3];
    logic signed [127:0] nrm[3];
    logic signed [127:0] num;
    logic signed [127:0] quo;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    int s, i, j;
    tphq_pkg::result_t r;
    pt[0] = q.point_x;  pt[1] = q.point_y;  pt[2] = q.point_z;
    va[0] = q.first_x;  va[1] = q.first_y;  va[2] = q.first_z;
    ab[0] = q.second_x; ab[1] = q.second_y; ab[2] = q.second_z;
    ac[0] = q.third_x;  ac[1] = q.third_y;  ac[2] = q.third_z;
    for (int k = 0; k < 3; k++) begin
      ab[k] = ab[k] - va[k];
      ac[k] = ac[k] - va[k];
    end
    nrm[0] = ab[1] * ac[2] - ab[2] * ac[1];
    nrm[1] = ab[2] * ac[0] - ab[0] * ac[2];
    nrm[2] = ab[0] * ac[1] - ab[1] * ac[0];
    s = 2 - int'(axis);
    i = (s + 1) % 3;
    j = (s + 2) % 3;
    r = '0;
    if (nrm[s] == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    num = -nrm[i] * (pt[i] - va[i]) - nrm[j] * (pt[j] - va[j]) + nrm[s] * va[s];
    quo = num / nrm[s];
    hi_lim = (128'sd1 <<< (tphq_pkg::CW - 1)) - 1;
    lo_lim = -(128'sd1 <<< (tphq_pkg::CW - 1));
    if (quo > hi_lim) begin
      quo = hi_lim;
      r.saturated = 1'b1;
    end else if (quo < lo_lim) begin
      quo = lo_lim;
      r.saturated = 1'b1;
    end
    r.height = quo[tphq_pkg::CW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    fail_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // driver: the predictor runs on each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_i <= '0;
    end else begin
      if (start && !busy) begin
        height_expect.push_back(plane_height(cmd_i, solve_axis));
        accepted_count++;
      end
      if (!start || !busy) begin
        if (query_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          start <= 1'b1;
          cmd_i <= query_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tphq_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (height_expect.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = height_expect.pop_front();
        if (res_o.height !== want.height)
          report_mismatch($sformatf("height %h, expected %h", res_o.height, want.height));
        if (res_o.degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate %b, expected %b",
                                    res_o.degenerate, want.degenerate));
        if (res_o.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %b, expected %b",
                                    res_o.saturated, want.saturated));
        if (want.degenerate) degenerate_seen++;
        if (want.saturated) saturated_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic tphq_pkg::coord_t rand_coord(int mode);
    case (mode)
      0: return tphq_pkg::coord_t'($urandom);
      1: return tphq_pkg::coord_t'($urandom_range(0, 1 << 15)) - tphq_pkg::coord_t'(1 << 14);
      2: return $urandom_range(1) ? tphq_pkg::coord_t'(1 << (tphq_pkg::CW - 1))
                                  : tphq_pkg::coord_t'((1 << (tphq_pkg::CW - 1)) - 1);
      default: return tphq_pkg::coord_t'($urandom_range(0, 1 << 18))
                      - tphq_pkg::coord_t'(1 << 17);
    endcase
  endfunction

  function automatic tphq_pkg::query_t rand_query();
    tphq_pkg::query_t q;
    int mode;
    int pick;
    pick = $urandom_range(99);
    mode = pick < 15 ? 0 : pick < 60 ? 1 : pick < 90 ? 3 : 2;
    q.point_x = rand_coord(mode);  q.point_y = rand_coord(mode);
    q.point_z = rand_coord(mode);  q.first_x = rand_coord(mode);
    q.first_y = rand_coord(mode);  q.first_z = rand_coord(mode);
    q.second_x = rand_coord(mode); q.second_y = rand_coord(mode);
    q.second_z = rand_coord(mode); q.third_x = rand_coord(mode);
    q.third_y = rand_coord(mode);  q.third_z = rand_coord(mode);
    // flat triangles now and then
    if ($urandom_range(9) == 0) begin
      q.third_x = q.second_x;
      q.third_y = q.second_y;
      q.third_z = q.second_z;
    end
    return q;
  endfunction

  task automatic wait_idle();
    while (query_backlog.size() > 0 || start || height_expect.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_axis(logic [1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (value != tphq_pkg::AXIS_BAD) solve_axis = value;
    @(posedge clk_i);
  endtask

  task automatic add_directed();
    tphq_pkg::query_t q;
    tphq_pkg::coord_t vmax;
    tphq_pkg::coord_t vmin;
    tphq_pkg::coord_t zero;
    tphq_pkg::coord_t one;
    tphq_pkg::coord_t unit;
    vmax = tphq_pkg::coord_t'((1 << (tphq_pkg::CW - 1)) - 1);
    vmin = tphq_pkg::coord_t'(1 << (tphq_pkg::CW - 1));
    zero = tphq_pkg::coord_t'(0);
    one  = tphq_pkg::coord_t'(1);
    unit = tphq_pkg::coord_t'(4096);
    q = '0;
    query_backlog.push_back(q);                        // all zero: degenerate
    q = {vmax, vmax, vmax, vmin, vmin, vmin, vmax, vmin, vmax, vmin, vmax, vmax};
    query_backlog.push_back(q);
    q = {vmin, vmin, vmin, vmax, vmax, vmax, vmin, vmax, vmin, vmax, vmin, vmin};
    query_backlog.push_back(q);
    q = {vmax, vmin, vmax, zero, zero, zero, one, zero, zero, zero, zero, one};
    query_backlog.push_back(q);                        // plane y = 0: zero height solving y, degenerate otherwise
    q = {vmin, vmax, vmin, zero, vmax, zero,
         one, vmax, one, tphq_pkg::coord_t'(-1), vmin, one};
    query_backlog.push_back(q);
    q = {unit, unit, unit, zero, zero, zero, unit, zero, zero, zero, unit, unit};
    query_backlog.push_back(q);
    q = {tphq_pkg::coord_t'(-1), tphq_pkg::coord_t'(-1), tphq_pkg::coord_t'(-1),
         tphq_pkg::coord_t'(3), tphq_pkg::coord_t'(-3), tphq_pkg::coord_t'(5),
         tphq_pkg::coord_t'(7), tphq_pkg::coord_t'(2), tphq_pkg::coord_t'(-9),
         tphq_pkg::coord_t'(-4), tphq_pkg::coord_t'(6), tphq_pkg::coord_t'(11)};
    query_backlog.push_back(q);                        // truncation toward zero
    q = {vmax, vmax, vmax, vmax, vmax, vmax, vmin, vmin, vmin, vmax, vmin, vmax};
    query_backlog.push_back(q);
  endtask

  initial begin
    logic [1:0] axis_plan[8];
    int         idle_plan[3];
    axis_plan = '{tphq_pkg::AXIS_Z, tphq_pkg::AXIS_X, tphq_pkg::AXIS_BAD, tphq_pkg::AXIS_Y,
                  tphq_pkg::AXIS_Z, tphq_pkg::AXIS_BAD, tphq_pkg::AXIS_X, tphq_pkg::AXIS_Y};
    idle_plan = '{34, 71, 0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    solve_axis = tphq_pkg::AXIS_Y;
    send_idle_pct = 0;
    fail_count = 0;
    accepted_count = 0;
    degenerate_seen = 0;
    saturated_seen = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // corner cases on every axis, the reset axis first
    for (int a = 0; a < 3; a++) begin
      if (a > 0) write_axis(a == 1 ? tphq_pkg::AXIS_Z : tphq_pkg::AXIS_X);
      add_directed();
      wait_idle();
    end
    for (int ph = 0; ph < 24; ph++) begin
      send_idle_pct = idle_plan[ph / 8];
      write_axis(axis_plan[ph % 8]);
      for (int n = 0; n < 78; n++) query_backlog.push_back(rand_query());
      wait_idle();
    end
    $display("%0d queries checked, %0d degenerate, %0d saturated, on all three axes",
             accepted_count, degenerate_seen, saturated_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tphq_pkg.sv
hw/rtl/tphq_front.sv
hw/rtl/tphq_queue.sv
hw/rtl/tphq_back.sv
hw/rtl/triangle_plane_height_query_unit.sv
dv/tb.sv
